[hdl/dam_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_pkg - shared types and constants for the digit anagram match counter
// Request and result layouts, opcodes and character constants.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int MAX_LEN_DEF     = 19;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int NUM_DIGITS      = 10;
  localparam int TOTAL_W         = 16;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 24;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_QUERY = 2'd1,
    OP_CAND  = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] char_code;
    logic       last;
  } dam_req_t;

  typedef struct packed {
    logic               valid;
    logic               is_match;
    logic               is_identical;
    logic [TOTAL_W-1:0] match_total;
  } dam_res_t;

endpackage

[hdl/digit_anagram_match_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_anagram_match_counter - digit anagram match counter
// Loads a query string, then reports per candidate whether its decimal digit
// histogram equals the query's while the text differs, with a running total.
//
//   channel | dir | tdata (low bit up)                      | tlast
//   in_     | in  | opcode[1:0], char_code[9:2], pad        | end of string
//   out_    | out | is_match[0], is_identical[1],           | -
//           |     | match_total[17:2], pad                  |
//
// One request per cycle unless a held result stalls the input; an accepted request
// is registered in the input register, then its result in the result register.
// Throughput is set by the single-pass update of histograms and query store.
// Reset clears all counts, lengths and the total; the query store is not swept.
// A held result stalls the input only while a request also waits in the input
// register.
// ----------------------------------------------------------------------------
module digit_anagram_match_counter import dam_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode, char_code
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // is_match, is_identical, match_total
);

  dam_req_t req_r;
  logic     req_v_r;
  dam_res_t res;
  dam_res_t res_r;
  logic     out_v_r;
  logic     adv;
  logic     step;

  assign adv       = !out_v_r || out_tready;
  assign step      = req_v_r && adv;
  assign in_tready = !req_v_r || adv;

  dam_core #(
    .MAX_LEN     (MAX_LEN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (req_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) req_v_r <= in_tvalid;
      if (adv) out_v_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      req_r.opcode    <= opcode_t'(in_tdata[1:0]);
      req_r.char_code <= in_tdata[9:2];
      req_r.last      <= in_tlast;
    end
    if (adv) res_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W-TOTAL_W-2){1'b0}}, res_r.match_total,
                       res_r.is_identical, res_r.is_match};

`ifndef SYNTHESIS
  a_cand_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && req_r.opcode == OP_CAND && req_r.last) |=> out_tvalid)
    else $error("candidate end produced no result");

  a_match_not_identical: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("result both match and identical");

  a_match_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[17:2] != 16'd0))
    else $error("match reported with zero total");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (req_v_r && out_tvalid && !out_tready))
    else $error("input stalled without a held result");
`endif

endmodule

[hdl/dam_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_core - digit histograms, query store and identity tracking
// Applies one request per step and returns the candidate verdict, if any.
// ----------------------------------------------------------------------------
module dam_core import dam_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  dam_req_t req,
  output dam_res_t res
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  logic [LW-1:0] qcnt_r [NUM_DIGITS];
  logic [LW-1:0] qcnt_nxt [NUM_DIGITS];
  logic [LW-1:0] ccnt_r [NUM_DIGITS];
  logic [LW-1:0] ccnt_nxt [NUM_DIGITS];
  logic [LW-1:0] qlen_r, qlen_nxt;
  logic [LW-1:0] cpos_r, cpos_nxt;
  logic          same_r, same_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;

  logic [7:0]    qmem [MAX_LEN];
  logic [7:0]    qrd_r;
  logic          wr_en;

  logic          is_digit;
  logic [3:0]    dig;
  logic          same_cur;
  logic [LW-1:0] cpos_cur;
  logic          counts_eq;
  logic          identical;
  logic          match;
  logic [TOTAL_W-1:0] total_out;

  assign is_digit = (req.char_code >= CHAR_ZERO) && (req.char_code <= CHAR_NINE);
  assign dig      = 4'(req.char_code - CHAR_ZERO);

  generate
    if (COUNT_WIDTH >= TOTAL_W) begin : g_tot_trunc
      assign total_out = total_nxt[TOTAL_W-1:0];
    end else begin : g_tot_ext
      assign total_out = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, total_nxt};
    end
  endgenerate

  always_comb begin
    qcnt_nxt  = qcnt_r;
    ccnt_nxt  = ccnt_r;
    qlen_nxt  = qlen_r;
    cpos_nxt  = cpos_r;
    same_nxt  = same_r;
    total_nxt = total_r;
    wr_en     = 1'b0;
    same_cur  = same_r;
    cpos_cur  = cpos_r;
    counts_eq = 1'b1;
    identical = 1'b0;
    match     = 1'b0;
    res       = '0;
    if (step) begin
      case (req.opcode)
        OP_CLEAR: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            qcnt_nxt[i] = '0;
            ccnt_nxt[i] = '0;
          end
          qlen_nxt  = '0;
          cpos_nxt  = '0;
          same_nxt  = 1'b1;
          total_nxt = '0;
        end
        OP_QUERY: begin
          if (qlen_r < LEN_MAX) begin
            wr_en    = 1'b1;
            qlen_nxt = qlen_r + 1'b1;
            if (is_digit) qcnt_nxt[dig] = qcnt_r[dig] + 1'b1;
          end
        end
        OP_CAND: begin
          if (cpos_r < LEN_MAX) begin
            if (is_digit) ccnt_nxt[dig] = ccnt_r[dig] + 1'b1;
            if (cpos_r >= qlen_r || qrd_r != req.char_code) same_cur = 1'b0;
            cpos_cur = cpos_r + 1'b1;
          end
          same_nxt = same_cur;
          cpos_nxt = cpos_cur;
          if (req.last) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
              if (ccnt_nxt[i] != qcnt_r[i]) counts_eq = 1'b0;
            end
            identical = same_cur && (cpos_cur == qlen_r);
            match     = counts_eq && !identical;
            if (match && total_r != {COUNT_WIDTH{1'b1}}) total_nxt = total_r + 1'b1;
            res.valid        = 1'b1;
            res.is_match     = match;
            res.is_identical = identical;
            res.match_total  = total_out;
            for (int i = 0; i < NUM_DIGITS; i++) ccnt_nxt[i] = '0;
            cpos_nxt = '0;
            same_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        qcnt_r[i] <= '0;
        ccnt_r[i] <= '0;
      end
      qlen_r  <= '0;
      cpos_r  <= '0;
      same_r  <= 1'b1;
      total_r <= '0;
    end else begin
      qcnt_r  <= qcnt_nxt;
      ccnt_r  <= ccnt_nxt;
      qlen_r  <= qlen_nxt;
      cpos_r  <= cpos_nxt;
      same_r  <= same_nxt;
      total_r <= total_nxt;
    end
  end

  // query store; read port prefetches the entry for the next candidate position
  always_ff @(posedge clk) begin
    if (wr_en) qmem[qlen_r[AW-1:0]] <= req.char_code;
    if (wr_en && qlen_r == cpos_nxt) begin
      qrd_r <= req.char_code;
    end else begin
      qrd_r <= qmem[cpos_nxt[AW-1:0]];
    end
  end

endmodule
